### hw/rtl/scalc_pkg.sv
// Shared types, key codes and helpers for the scancode calculator.
`default_nettype none

package scalc_pkg;

   // Internal operand width; result fields are always 32 bits.
   localparam int OPERAND_WIDTH = 32;
   localparam int OUT_WIDTH     = 32;
   localparam int DIV_CNT_WIDTH = $clog2(OPERAND_WIDTH);

   // Set-1 key codes (bit 7 stripped).
   localparam logic [6:0] KEY_DIGIT_LO   = 7'h02;
   localparam logic [6:0] KEY_DIGIT_ZERO = 7'h0B;
   localparam logic [6:0] KEY_ADD        = 7'h4E;
   localparam logic [6:0] KEY_SUB        = 7'h4A;
   localparam logic [6:0] KEY_MUL        = 7'h37;
   localparam logic [6:0] KEY_DIV        = 7'h35;
   localparam logic [6:0] KEY_CLEAR      = 7'h2E;
   localparam logic [6:0] KEY_ENTER      = 7'h1C;
   localparam logic [3:0] RADIX_DIGIT_OFS = 4'd1;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DIV0    = 2'd1,
      ST_NOOP    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   // Controller -> datapath
   typedef struct packed {
      logic latch_key;
      logic decode;
      logic mul_step;
      logic div_step;
      logic div_fix;
      logic load_rsp;
   } cmd_type;

   // Datapath -> controller, meaningful while decoding
   typedef struct packed {
      logic emit_now;
      logic start_mul;
      logic start_div;
   } stat_type;

   // Sign extend (or cut) an operand to the result field width.
   function automatic logic [OUT_WIDTH-1:0] to_out(input logic [OPERAND_WIDTH-1:0] v);
      logic [OUT_WIDTH+OPERAND_WIDTH-1:0] ext;
      ext = {{OUT_WIDTH{v[OPERAND_WIDTH-1]}}, v};
      return ext[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/scalc_ctrl.sv
// Sequencing state machine for the scancode calculator.
`default_nettype none

module scalc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  scalc_pkg::stat_type     stat,
   output scalc_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_MUL    = 6'b000100,
      S_DIV    = 6'b001000,
      S_DIVFIX = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type                             state_ff, state_in;
   logic [scalc_pkg::DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  out_free;
   logic                                  div_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_last  = (cnt_ff == scalc_pkg::DIV_CNT_WIDTH'(scalc_pkg::OPERAND_WIDTH - 1));
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_key = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            cnt_in     = '0;
            priority if (stat.start_mul) state_in = S_MUL;
            else if (stat.start_div)     state_in = S_DIV;
            else if (stat.emit_now)      state_in = S_EMIT;
            else                         state_in = S_IDLE;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_EMIT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (div_last) state_in = S_DIVFIX;
         end
         S_DIVFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_rsp)               rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/scalc_dp.sv
// Datapath: key flags, operands, multiplier, shift-subtract divider, result beat.
`default_nettype none

module scalc_dp (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  [7:0]                               req_scancode,
   input  scalc_pkg::cmd_type                       cmd,
   output scalc_pkg::stat_type                      stat,
   output logic [1:0]                               rsp_status,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_first_operand,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_second_operand,
   output logic [2:0]                               rsp_operator_code,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_value
);

   localparam int W = scalc_pkg::OPERAND_WIDTH;

   logic [7:0]               key_ff;
   logic [127:0]             held_ff, held_in;
   logic [W-1:0]             first_ff, first_in;
   logic [W-1:0]             second_ff, second_in;
   scalc_pkg::op_type        op_ff, op_in;
   logic                     on_second_ff, on_second_in;

   logic [W-1:0]             res_value_ff, res_value_in;
   scalc_pkg::status_type    res_status_ff, res_status_in;

   logic [W-1:0]             rem_ff, rem_in;
   logic [W-1:0]             quo_ff, quo_in;
   logic [W-1:0]             dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;

   logic [1:0]               rsp_status_ff;
   logic [scalc_pkg::OUT_WIDTH-1:0] rsp_first_ff, rsp_second_ff, rsp_value_ff;
   logic [2:0]               rsp_op_ff;

   logic [6:0]               key;
   logic                     release_key, held, press;
   logic                     is_digit;
   logic [3:0]               digit;
   logic [W-1:0]             cur, times10, entered;
   logic [2*W-1:0]           product;
   logic [W:0]               shifted, diff;
   logic                     ge;
   logic [W-1:0]             mag_a, mag_b;
   logic                     is_enter, is_clear;

   assign key         = key_ff[6:0];
   assign release_key = key_ff[7];
   assign held        = held_ff[key];
   assign press       = !release_key && !held;
   assign is_digit    = (key >= scalc_pkg::KEY_DIGIT_LO) && (key <= scalc_pkg::KEY_DIGIT_ZERO);
   assign digit       = (key == scalc_pkg::KEY_DIGIT_ZERO) ? 4'd0
                        : (key[3:0] - scalc_pkg::RADIX_DIGIT_OFS);
   assign is_enter    = press && (key == scalc_pkg::KEY_ENTER);
   assign is_clear    = press && (key == scalc_pkg::KEY_CLEAR);

   // operand * 10 + digit as shift-add
   assign cur     = on_second_ff ? second_ff : first_ff;
   assign times10 = {cur[W-4:0], 3'b000} + {cur[W-2:0], 1'b0};
   assign entered = times10 + {{(W-4){1'b0}}, digit};

   assign product = first_ff * second_ff;

   assign mag_a = first_ff[W-1]  ? (~first_ff + 1'b1)  : first_ff;
   assign mag_b = second_ff[W-1] ? (~second_ff + 1'b1) : second_ff;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = !diff[W];

   always_comb begin
      stat.start_mul = is_enter && (op_ff == scalc_pkg::OP_MUL);
      stat.start_div = is_enter && (op_ff == scalc_pkg::OP_DIV) && (second_ff != '0);
      stat.emit_now  = is_enter || is_clear;
   end

   always_comb begin
      held_in       = held_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      op_in         = op_ff;
      on_second_in  = on_second_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      neg_in        = neg_ff;

      if (cmd.decode) begin
         held_in[key] = !release_key;
         if (press) begin
            if (is_digit) begin
               if (on_second_ff) second_in = entered;
               else              first_in  = entered;
            end
            unique case (key)
               scalc_pkg::KEY_ADD: begin op_in = scalc_pkg::OP_ADD; on_second_in = 1'b1; end
               scalc_pkg::KEY_SUB: begin op_in = scalc_pkg::OP_SUB; on_second_in = 1'b1; end
               scalc_pkg::KEY_MUL: begin op_in = scalc_pkg::OP_MUL; on_second_in = 1'b1; end
               scalc_pkg::KEY_DIV: begin op_in = scalc_pkg::OP_DIV; on_second_in = 1'b1; end
               scalc_pkg::KEY_CLEAR: begin
                  first_in      = '0;
                  second_in     = '0;
                  op_in         = scalc_pkg::OP_NONE;
                  on_second_in  = 1'b0;
                  res_status_in = scalc_pkg::ST_CLEARED;
                  res_value_in  = '0;
               end
               scalc_pkg::KEY_ENTER: begin
                  res_status_in = scalc_pkg::ST_OK;
                  res_value_in  = '0;
                  unique case (op_ff)
                     scalc_pkg::OP_ADD: res_value_in = first_ff + second_ff;
                     scalc_pkg::OP_SUB: res_value_in = first_ff - second_ff;
                     scalc_pkg::OP_MUL: res_value_in = '0;
                     scalc_pkg::OP_DIV: begin
                        if (second_ff == '0) res_status_in = scalc_pkg::ST_DIV0;
                        rem_in = '0;
                        quo_in = mag_a;
                        dvs_in = mag_b;
                        neg_in = first_ff[W-1] ^ second_ff[W-1];
                     end
                     default: res_status_in = scalc_pkg::ST_NOOP;
                  endcase
               end
               default: ;
            endcase
         end
      end

      if (cmd.mul_step) res_value_in = product[W-1:0];

      if (cmd.div_step) begin
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
      end

      if (cmd.div_fix) res_value_in = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

      // operands clear once the result beat has captured them
      if (cmd.load_rsp) begin
         first_in     = '0;
         second_in    = '0;
         op_in        = scalc_pkg::OP_NONE;
         on_second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         op_ff        <= scalc_pkg::OP_NONE;
         on_second_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         op_ff        <= op_in;
         on_second_ff <= on_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_key) key_ff <= req_scancode;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      neg_ff        <= neg_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_first_ff  <= scalc_pkg::to_out(first_ff);
         rsp_second_ff <= scalc_pkg::to_out(second_ff);
         rsp_op_ff     <= op_ff;
         rsp_value_ff  <= scalc_pkg::to_out(res_value_ff);
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_first_operand  = rsp_first_ff;
   assign rsp_second_operand = rsp_second_ff;
   assign rsp_operator_code  = rsp_op_ff;
   assign rsp_value          = rsp_value_ff;

endmodule

`default_nettype wire

### hw/rtl/scancode_calculator.sv
// Top level of the scancode calculator: controller plus datapath.
`default_nettype none

// Four-function calculator fed with raw set-1 keyboard scancode bytes, one
// byte per input beat. Releases (bit 7 set) clear the key's held flag; a
// press of a key already held is dropped, so auto-repeat has no effect.
// Digit keys shift a decimal digit into the current operand (wrapping),
// operator keys select +, -, * or / and move entry to the second operand.
// C clears the operands and operator and returns a "cleared" beat; Enter
// returns one beat with the result (or divide-by-zero / no-operator status)
// showing the operands and operator as entered, then clears them. Division
// truncates towards zero. All other keys return nothing.
// Sequence: a byte is taken in IDLE and decoded in DECODE; most keys end
// there. Enter with +, - or no operator, and C, go on to EMIT to load the
// result beat; multiply first passes through MUL for the registered
// product, and divide by a nonzero divisor runs the shift-subtract divider
// in DIV over every quotient bit, then a sign fix-up in DIVFIX.
// Input is stalled while a byte is being worked on. The result register is
// separate, so new bytes are taken while a result beat waits downstream;
// only a second result blocks until the first has gone.

module scancode_calculator (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  [7:0]                               req_scancode,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_first_operand,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_second_operand,
   output logic [2:0]                               rsp_operator_code,
   output logic signed [scalc_pkg::OUT_WIDTH-1:0]   rsp_value
);

   scalc_pkg::cmd_type  cmd;
   scalc_pkg::stat_type stat;

   // sequencing: accept, decode, multiply / divide steps, result beat
   scalc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // held flags, operands, arithmetic and the output register
   scalc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_scancode       (req_scancode),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_first_operand  (rsp_first_operand),
      .rsp_second_operand (rsp_second_operand),
      .rsp_operator_code  (rsp_operator_code),
      .rsp_value          (rsp_value)
   );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the scancode calculator: stimulus queue, driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;

   // ---------------------------------------------------------------------
   // Run sizing
   // ---------------------------------------------------------------------
   localparam int RANDOM_ITEMS = 1250;   // non-ignored random bytes
   localparam int SETTLE_CYCLES = 40;    // quiet time once all results are in
   localparam int DRAIN_CYCLES = 80;     // tail after the last result
   localparam int CYCLE_LIMIT = 600000;  // hard stop, well above a slow run
   localparam int RADIX = 10;
   localparam logic [7:0] RELEASE_BIT = 8'h80;

   // Idling phases
   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_SEND = 2'd1;
   localparam logic [1:0] PH_RECV = 2'd2;
   localparam logic [1:0] PH_BOTH = 2'd3;

   // One expected result beat
   typedef struct packed {
      scalc_pkg::status_type status;
      logic [31:0]           first_operand;
      logic [31:0]           second_operand;
      scalc_pkg::op_type     operator_code;
      logic [31:0]           value;
   } calc_beat_type;

   // One entry of the stimulus queue: a scancode byte, or a hold-off marker
   typedef struct packed {
      logic       hold_off;
      logic [7:0] code;
      logic [1:0] phase;
   } key_item_type;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_scancode = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic signed [scalc_pkg::OUT_WIDTH-1:0] rsp_first_operand;
   logic signed [scalc_pkg::OUT_WIDTH-1:0] rsp_second_operand;
   logic [2:0]  rsp_operator_code;
   logic signed [scalc_pkg::OUT_WIDTH-1:0] rsp_value;

   scancode_calculator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_scancode       (req_scancode),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_first_operand  (rsp_first_operand),
      .rsp_second_operand (rsp_second_operand),
      .rsp_operator_code  (rsp_operator_code),
      .rsp_value          (rsp_value)
   );

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   key_item_type  key_queue[$];       // bytes still to be sent
   calc_beat_type result_queue[$];    // results predicted, not yet seen
   int         error_count = 0;
   int         cycle_count = 0;
   logic [1:0] cur_phase = PH_NONE;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int send_idle_pct(input logic [1:0] ph);
      case (ph)
         PH_SEND: return 58;
         PH_BOTH: return 27;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(input logic [1:0] ph);
      case (ph)
         PH_RECV: return 58;
         PH_BOTH: return 27;
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Calculator predictor: its own copy of held flags, operands, operator
   // ---------------------------------------------------------------------
   logic              key_down[128];
   logic [31:0]       calc_first;
   logic [31:0]       calc_second;
   scalc_pkg::op_type calc_op;
   logic              calc_on_second;

   task automatic calc_clear();
      calc_first = '0;
      calc_second = '0;
      calc_op = scalc_pkg::OP_NONE;
      calc_on_second = 1'b0;
   endtask

   task automatic calc_apply_key(input logic [7:0] sc);
      logic [6:0]    key;
      logic [31:0]   digit;
      longint        num;
      longint        den;
      longint        quot;
      calc_beat_type beat;
      key = sc[6:0];
      if (sc[7]) begin
         key_down[key] = 1'b0;               // release: no result
      end else if (!key_down[key]) begin     // held key pressed again is dropped
         key_down[key] = 1'b1;
         if (key >= scalc_pkg::KEY_DIGIT_LO && key <= scalc_pkg::KEY_DIGIT_ZERO) begin
            digit = (key == scalc_pkg::KEY_DIGIT_ZERO) ? 32'd0
                    : 32'(key - scalc_pkg::RADIX_DIGIT_OFS);
            if (calc_on_second) calc_second = calc_second * RADIX + digit;
            else                calc_first  = calc_first * RADIX + digit;
         end else begin
            case (key)
               scalc_pkg::KEY_ADD: begin
                  calc_op = scalc_pkg::OP_ADD; calc_on_second = 1'b1;
               end
               scalc_pkg::KEY_SUB: begin
                  calc_op = scalc_pkg::OP_SUB; calc_on_second = 1'b1;
               end
               scalc_pkg::KEY_MUL: begin
                  calc_op = scalc_pkg::OP_MUL; calc_on_second = 1'b1;
               end
               scalc_pkg::KEY_DIV: begin
                  calc_op = scalc_pkg::OP_DIV; calc_on_second = 1'b1;
               end
               scalc_pkg::KEY_CLEAR: begin
                  // cleared beat shows the state after the clear
                  calc_clear();
                  beat = '{scalc_pkg::ST_CLEARED, 32'd0, 32'd0, scalc_pkg::OP_NONE, 32'd0};
                  result_queue.push_back(beat);
               end
               scalc_pkg::KEY_ENTER: begin
                  // enter beat shows operands and operator as entered
                  beat = '{scalc_pkg::ST_OK, calc_first, calc_second, calc_op, 32'd0};
                  case (calc_op)
                     scalc_pkg::OP_ADD: beat.value = calc_first + calc_second;
                     scalc_pkg::OP_SUB: beat.value = calc_first - calc_second;
                     scalc_pkg::OP_MUL: beat.value = calc_first * calc_second;
                     scalc_pkg::OP_DIV: begin
                        if (calc_second == 32'd0) begin
                           beat.status = scalc_pkg::ST_DIV0;
                        end else begin
                           // 64-bit divide truncates toward zero; the low word
                           // gives the wrap of most negative over minus one
                           num = longint'($signed(calc_first));
                           den = longint'($signed(calc_second));
                           quot = num / den;
                           beat.value = quot[31:0];
                        end
                     end
                     default: beat.status = scalc_pkg::ST_NOOP;
                  endcase
                  result_queue.push_back(beat);
                  calc_clear();
               end
               default: ;                    // any other key just sets its flag
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents queued bytes, holds a stalled beat, obeys hold-offs
   // ---------------------------------------------------------------------
   int settle_count = 0;

   always @(posedge clock) begin
      logic         next_valid;
      logic [7:0]   next_code;
      key_item_type head;
      if (reset) begin
         req_valid <= 1'b0;
         req_scancode <= 8'h00;
      end else begin
         // byte taken at this edge: predict it now
         if (req_valid && !req_stall) calc_apply_key(req_scancode);
         if (!(req_valid && req_stall)) begin
            next_valid = 1'b0;
            next_code = req_scancode;
            if (key_queue.size() != 0) begin
               head = key_queue[0];
               if (head.hold_off) begin
                  // sender waits for every result, then a little longer
                  if (result_queue.size() == 0) begin
                     if (settle_count >= SETTLE_CYCLES) begin
                        void'(key_queue.pop_front());
                        settle_count = 0;
                     end else begin
                        settle_count++;
                     end
                  end else begin
                     settle_count = 0;
                  end
               end else if ($urandom_range(99) >= send_idle_pct(head.phase)) begin
                  void'(key_queue.pop_front());
                  next_valid = 1'b1;
                  next_code = head.code;
                  cur_phase <= head.phase;
               end
            end
            req_valid <= next_valid;
            req_scancode <= next_code;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random stall, each accepted beat checked against the oldest
   // expectation, field by field
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      calc_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (result_queue.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual status %0d value %h",
                        $realtime, rsp_status, rsp_value);
               error_count++;
            end else begin
               want = result_queue.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("first_operand", want.first_operand, rsp_first_operand);
               check_field("second_operand", want.second_operand, rsp_second_operand);
               check_field("operator_code", 32'(want.operator_code), 32'(rsp_operator_code));
               check_field("value", want.value, rsp_value);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct(cur_phase));
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus generation; its own record of which keys it left held
   // ---------------------------------------------------------------------
   logic       gen_down[128];
   int         live_count = 0;     // bytes that do more than get dropped
   logic [1:0] gen_phase = PH_NONE;

   task automatic push_byte(input logic [7:0] code);
      key_item_type item;
      if (code[7] || !gen_down[code[6:0]]) live_count++;
      gen_down[code[6:0]] = !code[7];
      item = '{1'b0, code, gen_phase};
      key_queue.push_back(item);
   endtask

   task automatic push_hold_off();
      key_item_type item;
      item = '{1'b1, 8'h00, gen_phase};
      key_queue.push_back(item);
   endtask

   // Press a key, releasing it first if still held; release after at random
   task automatic tap(input logic [6:0] key);
      if (gen_down[key]) push_byte(RELEASE_BIT | {1'b0, key});
      push_byte({1'b0, key});
      if ($urandom_range(1) == 1) push_byte(RELEASE_BIT | {1'b0, key});
   endtask

   task automatic tap_digit(input int d);
      tap((d == 0) ? scalc_pkg::KEY_DIGIT_ZERO : 7'(d + 1));
   endtask

   task automatic type_number(input string s);
      for (int i = 0; i < s.len(); i++) tap_digit(s[i] - "0");
   endtask

   task automatic type_random_number();
      int n;
      n = ($urandom_range(3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++) tap_digit($urandom_range(9));
   endtask

   task automatic random_sequence();
      logic [6:0] op_keys[4];
      int         kind;
      op_keys = '{scalc_pkg::KEY_ADD, scalc_pkg::KEY_SUB,
                  scalc_pkg::KEY_MUL, scalc_pkg::KEY_DIV};
      kind = $urandom_range(99);
      type_random_number();
      if (kind < 8) begin
         tap(scalc_pkg::KEY_ENTER);          // no operator chosen
      end else begin
         tap(op_keys[$urandom_range(3)]);
         if (kind < 16) tap(op_keys[$urandom_range(3)]);   // operator changed
         if (kind >= 16 && kind < 26) tap_digit(0);       // lone zero, often /0
         else type_random_number();
         if (kind >= 26 && kind < 32) tap(scalc_pkg::KEY_CLEAR);   // clear mid-entry
         if (kind >= 32 && kind < 40) push_byte(8'($urandom_range(255)));
         tap(scalc_pkg::KEY_ENTER);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int idx;
      for (int k = 0; k < 128; k++) begin
         key_down[k] = 1'b0;
         gen_down[k] = 1'b0;
      end
      calc_clear();

      // Directed part, no idling
      push_byte(8'h00);                       // other keys: flag only
      push_byte(8'h7F);
      push_byte(8'hFF);                       // releases never emit
      push_byte(8'h80);
      push_byte({1'b0, scalc_pkg::KEY_ENTER});   // enter without operator
      type_number("12"); tap(scalc_pkg::KEY_ADD); type_number("34");
      tap(scalc_pkg::KEY_ENTER);
      type_number("5"); tap(scalc_pkg::KEY_SUB); type_number("9");
      tap(scalc_pkg::KEY_ENTER);
      type_number("7"); tap(scalc_pkg::KEY_MUL); type_number("6");
      tap(scalc_pkg::KEY_ENTER);
      type_number("9"); tap(scalc_pkg::KEY_DIV); type_number("0");   // divide by zero
      tap(scalc_pkg::KEY_ENTER);
      // most negative over minus one, both entered by wrapping
      type_number("2147483648"); tap(scalc_pkg::KEY_DIV); type_number("4294967295");
      tap(scalc_pkg::KEY_ENTER);
      // auto-repeat: second press of a held digit is dropped
      push_byte(8'h00 | 8'(scalc_pkg::KEY_DIGIT_LO + 7'd2));
      push_byte(8'h00 | 8'(scalc_pkg::KEY_DIGIT_LO + 7'd2));
      tap(scalc_pkg::KEY_CLEAR);              // cleared beat
      tap(scalc_pkg::KEY_ENTER);
      push_hold_off();

      // Random part over four idling phases
      idx = live_count;
      while (live_count - idx < RANDOM_ITEMS) begin
         if (gen_phase != 2'((live_count - idx) * 4 / RANDOM_ITEMS)) begin
            push_hold_off();
            gen_phase = 2'((live_count - idx) * 4 / RANDOM_ITEMS);
         end
         case ($urandom_range(9))
            0: push_byte(8'($urandom_range(255)));                      // noise
            1: begin                                                    // auto-repeat
               push_byte({1'b0, 7'($urandom_range(127))});
               push_byte(key_queue[$].code);
            end
            default: random_sequence();
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to go out and every result to come back
      while (key_queue.size() != 0 || req_valid) @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

endmodule
